// ----- src/rmfh_pkg.sv -----
// ----------------------------------------------------------------------------
// rmfh_pkg
// Shared types and constants for the recursive mutex with FIFO handoff.
// ----------------------------------------------------------------------------
package rmfh_pkg;

    localparam int TASK_W    = 6;
    localparam int TASK_COUNT = 64;

    localparam logic CMD_LOCK   = 1'b0;
    localparam logic CMD_UNLOCK = 1'b1;

    typedef enum logic [3:0] {
        OC_ACQUIRED    = 4'd0,
        OC_RECURSED    = 4'd1,
        OC_QUEUED      = 4'd2,
        OC_DECREMENTED = 4'd3,
        OC_FREED       = 4'd4,
        OC_HANDOFF     = 4'd5,
        OC_NOT_OWNER   = 4'd6,
        OC_QUEUE_FULL  = 4'd7,
        OC_SATURATED   = 4'd8
    } outcome_t;

    typedef struct packed {
        logic              command;
        logic [TASK_W-1:0] task_id;
    } req_t;

    typedef struct packed {
        outcome_t          outcome;
        logic              woken_valid;
        logic [TASK_W-1:0] woken_task;
        logic              is_locked;
        logic [TASK_W-1:0] owner_task;
        logic [7:0]        hold_depth;
        logic [6:0]        waiting_total;
    } rsp_t;

    // Broadcast from the controller to every queue cell.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [TASK_W-1:0] push_id;
    } cell_ctrl_t;

endpackage

// ----- src/recursive_mutex_fifo_handoff_top.sv -----
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff_top
// Recursive lock with a first-in first-out queue of waiting tasks.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one lock or unlock item
//   from a task; rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one
//   result item per request: outcome code, woken task, and the owner, hold
//   depth and queue occupancy after the request.
//   The result is registered: a request accepted at edge N is offered on rsp
//   from edge N onward. Throughput is one item per cycle; req_ready stays
//   high while the result register is empty or being drained, so a stalled
//   receiver back-pressures the requester after one item.
//   The wait queue is a row of WAIT_DEPTH cells. The head is always cell 0,
//   a dequeue shifts every cell one place toward the head, and an enqueue
//   writes the cell selected by the fill count, so each request takes the
//   owner compare plus a single queue step.
//   Reset clears ownership, the hold count and the fill count; queue cells
//   hold no reset value and are only read once written. No sweep is needed.
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_handoff_top #(
    parameter int WAIT_DEPTH = 64,
    parameter int MAX_HOLD   = 255
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  rmfh_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output rmfh_pkg::rsp_t rsp
);
    import rmfh_pkg::*;

    localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_HOLD + 1);

    // owner state
    logic              holder_valid_reg, holder_valid_next;
    logic [TASK_W-1:0] holder_id_reg, holder_id_next;
    logic [CNT_W-1:0]  hold_count_reg, hold_count_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // result register
    logic rsp_valid_reg;
    rsp_t rsp_reg, rsp_next;

    logic       accept;
    logic       task_ok;
    logic       is_owner;
    outcome_t   outcome;
    logic       woken_valid;
    logic [TASK_W-1:0] woken_task;
    cell_ctrl_t ctrl;

    // queue cell outputs, cell 0 is the head
    logic [TASK_W-1:0] cell_id [WAIT_DEPTH];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign task_ok   = 32'(req.task_id) < TASK_COUNT;
    assign is_owner  = holder_valid_reg && (holder_id_reg == req.task_id);

    always_comb
    begin
        holder_valid_next = holder_valid_reg;
        holder_id_next    = holder_id_reg;
        hold_count_next   = hold_count_reg;
        fill_next         = fill_reg;
        woken_valid       = 1'b0;
        woken_task        = '0;
        ctrl.push         = 1'b0;
        ctrl.pop          = 1'b0;
        ctrl.push_id      = req.task_id;
        outcome           = OC_NOT_OWNER;

        if (!task_ok)
        begin
            outcome = OC_NOT_OWNER;
        end
        else if (req.command == CMD_LOCK)
        begin
            if (!holder_valid_reg)
            begin
                holder_valid_next = 1'b1;
                holder_id_next    = req.task_id;
                hold_count_next   = CNT_W'(1);
                outcome           = OC_ACQUIRED;
            end
            else if (is_owner)
            begin
                if (hold_count_reg == CNT_W'(MAX_HOLD))
                begin
                    outcome = OC_SATURATED;
                end
                else
                begin
                    hold_count_next = hold_count_reg + CNT_W'(1);
                    outcome         = OC_RECURSED;
                end
            end
            else if (fill_reg == FILL_W'(WAIT_DEPTH))
            begin
                outcome = OC_QUEUE_FULL;
            end
            else
            begin
                ctrl.push = accept;
                fill_next = fill_reg + FILL_W'(1);
                outcome   = OC_QUEUED;
            end
        end
        else
        begin
            if (!is_owner)
            begin
                outcome = OC_NOT_OWNER;
            end
            else if (hold_count_reg > CNT_W'(1))
            begin
                hold_count_next = hold_count_reg - CNT_W'(1);
                outcome         = OC_DECREMENTED;
            end
            else if (fill_reg == '0)
            begin
                holder_valid_next = 1'b0;
                holder_id_next    = '0;
                hold_count_next   = '0;
                outcome           = OC_FREED;
            end
            else
            begin
                // hand the lock to the head waiter
                ctrl.pop        = accept;
                woken_valid     = 1'b1;
                woken_task      = cell_id[0];
                holder_id_next  = cell_id[0];
                hold_count_next = CNT_W'(1);
                fill_next       = fill_reg - FILL_W'(1);
                outcome         = OC_HANDOFF;
            end
        end

        rsp_next.outcome       = outcome;
        rsp_next.woken_valid   = woken_valid;
        rsp_next.woken_task    = woken_task;
        rsp_next.is_locked     = holder_valid_next;
        rsp_next.owner_task    = holder_valid_next ? holder_id_next : '0;
        rsp_next.hold_depth    = holder_valid_next ? 8'(hold_count_next) : 8'd0;
        rsp_next.waiting_total = 7'(fill_next);
    end

    // wait queue: a row of cells shifting toward the head on a pop
    for (genvar i = 0; i < WAIT_DEPTH; i++)
    begin : g_cell
        logic [TASK_W-1:0] right_id;
        if (i + 1 < WAIT_DEPTH)
        begin : g_mid
            assign right_id = cell_id[i+1];
        end
        else
        begin : g_last
            assign right_id = cell_id[i];
        end

        rmfh_cell #(
            .FILL_W (FILL_W),
            .INDEX  (i)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .fill    (fill_reg),
            .next_id (right_id),
            .id      (cell_id[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holder_valid_reg <= 1'b0;
            holder_id_reg    <= '0;
            hold_count_reg   <= '0;
            fill_reg         <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                holder_valid_reg <= holder_valid_next;
                holder_id_reg    <= holder_id_next;
                hold_count_reg   <= hold_count_next;
                fill_reg         <= fill_next;
                rsp_valid_reg    <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- src/rmfh_cell.sv -----
// ----------------------------------------------------------------------------
// rmfh_cell
// One slot of the wait queue. On a pop it takes its right neighbor's task;
// on a push it loads the new task when the fill count points at it.
// ----------------------------------------------------------------------------
module rmfh_cell #(
    parameter int FILL_W = 7,
    parameter int INDEX  = 0
) (
    input  logic                                clk,
    input  rmfh_pkg::cell_ctrl_t                ctrl,
    input  logic [FILL_W-1:0]                   fill,
    input  logic [rmfh_pkg::TASK_W-1:0]         next_id,
    output logic [rmfh_pkg::TASK_W-1:0]         id
);
    import rmfh_pkg::*;

    logic [TASK_W-1:0] id_reg;
    logic [TASK_W-1:0] id_next;

    always_comb
    begin
        id_next = id_reg;
        if (ctrl.pop)
        begin
            id_next = next_id;
        end
        else if (ctrl.push && (fill == FILL_W'(INDEX)))
        begin
            id_next = ctrl.push_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule
